/* rtl/core/cpdr_pkg.sv */
// ----------------------------------------------------------------------------
// cpdr_pkg: shared types and constants
// cascade controller sequencer states, register indexes and format constants
// ----------------------------------------------------------------------------
package cpdr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_REGS       = 8;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [2:0] {
        REG_OUTER_KP  = 3'd0,
        REG_OUTER_KI  = 3'd1,
        REG_OUTER_KD  = 3'd2,
        REG_INNER_KP  = 3'd3,
        REG_INNER_KI  = 3'd4,
        REG_INNER_KD  = 3'd5,
        REG_OUTER_LIM = 3'd6,
        REG_INNER_LIM = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_OUT_INT,
        ST_OUT_DER,
        ST_OUT_FLT,
        ST_OUT_MP,
        ST_OUT_MI,
        ST_OUT_MD,
        ST_INN_ERR,
        ST_INN_INT,
        ST_INN_DER,
        ST_INN_MP,
        ST_INN_MI,
        ST_INN_MD,
        ST_DONE
    } t_state;

    // multiplier / divider unit operation request
    typedef enum logic [1:0] {
        OP_QMUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_mul_ctl;

endpackage

/* rtl/core/cpdr_if.sv */
// ----------------------------------------------------------------------------
// cpdr_in_if / cpdr_out_if: valid/ready channels
// input ticks and result transactions of the cascade controller
// ----------------------------------------------------------------------------
interface cpdr_in_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;
    logic                         wrap_angle;
    logic                         outer_filter_on;
    logic                         inner_filter_on;
    modport source (output valid, target, measured, wrap_angle, outer_filter_on,
                    inner_filter_on, input ready);
    modport sink (input valid, target, measured, wrap_angle, outer_filter_on,
                  inner_filter_on, output ready);
endinterface

interface cpdr_out_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic signed [DATA_WIDTH-1:0] outer_command;
    modport source (output valid, drive, outer_command, input ready);
    modport sink (input valid, drive, outer_command, output ready);
endinterface

/* rtl/core/cascade_pid_derived_rate.sv */
// ----------------------------------------------------------------------------
// cascade_pid_derived_rate: cascade PID with derived measurement rate
// outer angle loop feeding an inner rate loop, shared bit-serial arithmetic
// ----------------------------------------------------------------------------
// channel  dir  payload                                         handshake
// in       in   target, measured, wrap_angle, *_filter_on      valid/ready
// out      out  drive, outer_command                            valid/ready
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data                write strobe
//
// each pass of the bit-serial multiply/divide unit issues the operation,
// runs its serial steps, finishes and hands the result back
// one tick is 8 passes (six gain products, two integrator divides by 500)
// plus sequencer steps, one more pass when the outer filter divide runs
// the sequencer handles one transaction at a time; the result register
// frees the sequencer, so the next tick starts while a result is held
// reset clears state, config registers and handshakes
module cascade_pid_derived_rate import cpdr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    cpdr_in_if.sink               in_ch,
    cpdr_out_if.source            out_ch
);
    localparam int W  = DATA_WIDTH;
    localparam int AW = W + 4;
    localparam int XW = W + 12;
    localparam logic signed [XW-1:0] VMAX = XW'((65'sd1 <<< (W - 1)) - 65'sd1);
    localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);
    localparam logic signed [XW-1:0] D180 = XW'(180) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] D360 = XW'(360) <<< FRAC_BITS;

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        if (v > VMAX) return W'(VMAX);
        if (v < VMIN) return W'(VMIN);
        return W'(v);
    endfunction

    // config
    logic signed [W-1:0] r_cfg [NUM_REGS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_cfg[k] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_OUTER_LIM || i_cfg_idx == REG_INNER_LIM) begin
                r_cfg[i_cfg_idx] <= {1'b0, i_cfg_data[W-2:0]};
            end else begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // state
    t_state r_st, n_st;
    logic signed [W-1:0] r_prev_m, r_oint, r_osm, r_prev_r, r_iint, r_ism;
    logic signed [W-1:0] n_prev_m, n_oint, n_osm, n_prev_r, n_iint, n_ism;
    // per-tick work registers
    logic signed [W-1:0] r_tgt, r_meas, r_e, r_d, r_ds, r_oc, r_rate;
    logic signed [W-1:0] n_tgt, n_meas, n_e, n_d, n_ds, n_oc, n_rate;
    // product sum kept wide, saturated once after the third term
    logic signed [XW-1:0] r_sum, n_sum;
    logic signed [W-1:0] r_ei, r_di, n_ei, n_di;
    logic r_wrap, r_of, r_if, n_wrap, n_of, n_if, r_wait, n_wait;
    logic r_ov, n_ov;
    logic signed [W-1:0] r_drv, r_ocmd, n_drv, n_ocmd;

    t_mul_ctl             mctl;
    logic signed [AW-1:0] ma;
    logic        [W-1:0]  mb;
    logic                 mbusy;
    logic signed [W-1:0]  mres;

    cpdr_serial_mac #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mctl), .i_a(ma), .i_b(mb),
        .o_busy(mbusy), .o_res(mres)
    );

    logic signed [XW-1:0] tmp;
    logic signed [W-1:0]  lim;
    logic                 unit_done;

    assign in_ch.ready      = (r_st == ST_IDLE);
    assign out_ch.valid     = r_ov;
    assign out_ch.drive     = r_drv;
    assign out_ch.outer_command = r_ocmd;

    always_comb begin
        n_st = r_st;
        n_prev_m = r_prev_m; n_oint = r_oint; n_osm = r_osm;
        n_prev_r = r_prev_r; n_iint = r_iint; n_ism = r_ism;
        n_tgt = r_tgt; n_meas = r_meas; n_e = r_e; n_d = r_d; n_ds = r_ds;
        n_sum = r_sum; n_oc = r_oc; n_rate = r_rate; n_ei = r_ei; n_di = r_di;
        n_wrap = r_wrap; n_of = r_of; n_if = r_if; n_wait = r_wait;
        n_ov = r_ov; n_drv = r_drv; n_ocmd = r_ocmd;
        mctl = '{start: 1'b0, op: OP_QMUL};
        ma = '0; mb = '0; tmp = '0; lim = '0;
        // each unit step: issue once, then wait for completion
        unit_done = r_wait && !mbusy;
        if (r_ov && out_ch.ready) n_ov = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    n_tgt = in_ch.target; n_meas = in_ch.measured;
                    n_wrap = in_ch.wrap_angle; n_of = in_ch.outer_filter_on;
                    n_if = in_ch.inner_filter_on;
                    n_st = ST_ERR;
                end
            end
            ST_ERR: begin
                tmp = XW'(r_tgt) - XW'(r_meas);
                n_e = sat(tmp);
                if (r_wrap) begin
                    if (XW'(n_e) > D180) n_e = sat(XW'(n_e) - D360);
                    else if (XW'(n_e) < -D180) n_e = sat(XW'(n_e) + D360);
                end
                n_d = sat((XW'(r_prev_m) - XW'(r_meas)) * XW'(500));
                n_prev_m = r_meas;
                n_st = ST_OUT_INT;
            end
            ST_OUT_INT: begin
                ma = AW'(r_e); mb = W'(500); lim = r_cfg[REG_OUTER_LIM];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_DIV}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0;
                    n_oint = sat(XW'(r_oint) + XW'(mres));
                    if (n_oint > lim) n_oint = lim;
                    else if (n_oint < -lim) n_oint = -lim;
                    n_st = ST_OUT_DER;
                end
            end
            ST_OUT_DER: begin
                n_ds = r_d;
                n_st = r_of ? ST_OUT_FLT : ST_OUT_MP;
            end
            ST_OUT_FLT: begin
                // 3*old + 7*d needs up to W+4 bits, divided unsaturated
                tmp = XW'(r_osm) * XW'(3) + XW'(r_d) * XW'(7);
                ma = AW'(tmp);
                mb = W'(10);
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_DIV}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0;
                    n_osm = mres; n_ds = mres;
                    n_st = ST_OUT_MP;
                end
            end
            ST_OUT_MP: begin
                ma = AW'(r_e); mb = r_cfg[REG_OUTER_KP];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_sum = XW'(mres); n_st = ST_OUT_MI;
                end
            end
            ST_OUT_MI: begin
                ma = AW'(r_oint); mb = r_cfg[REG_OUTER_KI];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_sum = r_sum + XW'(mres);
                    n_st = ST_OUT_MD;
                end
            end
            ST_OUT_MD: begin
                ma = AW'(r_ds); mb = r_cfg[REG_OUTER_KD];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_oc = sat(r_sum + XW'(mres));
                    n_st = ST_INN_ERR;
                end
            end
            ST_INN_ERR: begin
                n_rate = sat(-XW'(r_d));
                n_ei = sat(XW'(r_oc) - XW'(n_rate));
                n_di = sat((XW'(r_prev_r) - XW'(n_rate)) * XW'(500));
                n_prev_r = n_rate;
                n_st = ST_INN_INT;
            end
            ST_INN_INT: begin
                ma = AW'(r_ei); mb = W'(500); lim = r_cfg[REG_INNER_LIM];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_DIV}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0;
                    n_iint = sat(XW'(r_iint) + XW'(mres));
                    if (n_iint > lim) n_iint = lim;
                    else if (n_iint < -lim) n_iint = -lim;
                    n_st = ST_INN_DER;
                end
            end
            ST_INN_DER: begin
                if (r_if) begin
                    // (old + di)/2 rounded away from zero
                    tmp = XW'(r_ism) + XW'(r_di);
                    if (tmp < 0) tmp = -((-tmp + XW'(1)) >>> 1);
                    else tmp = (tmp + XW'(1)) >>> 1;
                    n_ism = sat(tmp); n_di = n_ism;
                end
                n_st = ST_INN_MP;
            end
            ST_INN_MP: begin
                ma = AW'(r_ei); mb = r_cfg[REG_INNER_KP];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_sum = XW'(mres); n_st = ST_INN_MI;
                end
            end
            ST_INN_MI: begin
                ma = AW'(r_iint); mb = r_cfg[REG_INNER_KI];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_sum = r_sum + XW'(mres);
                    n_st = ST_INN_MD;
                end
            end
            ST_INN_MD: begin
                ma = AW'(r_di); mb = r_cfg[REG_INNER_KD];
                if (!r_wait) begin
                    mctl = '{start: 1'b1, op: OP_QMUL}; n_wait = 1'b1;
                end else if (unit_done) begin
                    n_wait = 1'b0; n_sum = r_sum + XW'(mres);
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                // result register must be free before handing over
                if (!r_ov || out_ch.ready) begin
                    n_ov = 1'b1; n_drv = sat(r_sum); n_ocmd = r_oc;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_wait <= 1'b0; r_ov <= 1'b0;
            r_prev_m <= '0; r_oint <= '0; r_osm <= '0;
            r_prev_r <= '0; r_iint <= '0; r_ism <= '0;
        end else begin
            r_st <= n_st; r_wait <= n_wait; r_ov <= n_ov;
            r_prev_m <= n_prev_m; r_oint <= n_oint; r_osm <= n_osm;
            r_prev_r <= n_prev_r; r_iint <= n_iint; r_ism <= n_ism;
        end
        r_tgt <= n_tgt; r_meas <= n_meas; r_e <= n_e; r_d <= n_d; r_ds <= n_ds;
        r_sum <= n_sum; r_oc <= n_oc; r_rate <= n_rate; r_ei <= n_ei;
        r_di <= n_di; r_wrap <= n_wrap; r_of <= n_of; r_if <= n_if;
        r_drv <= n_drv; r_ocmd <= n_ocmd;
    end

    // integrators stay at or below their clamps, a stalled result holds, an accepted tick starts
    a_oint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT_DER) |-> (r_oint <= r_cfg[REG_OUTER_LIM]))
        else $error("outer integrator above limit");
    a_iint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_INN_DER) |-> (r_iint <= r_cfg[REG_INNER_LIM]))
        else $error("inner integrator above limit");
    a_outhold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> (r_ov && $stable(r_drv)))
        else $error("result dropped while stalled");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> (r_st == ST_ERR))
        else $error("accepted tick not started");
endmodule

/* rtl/core/cpdr_serial_mac.sv */
// ----------------------------------------------------------------------------
// cpdr_serial_mac: bit-serial signed multiplier and constant divider
// one multiplier bit, or one quotient bit, per cycle
// ----------------------------------------------------------------------------
module cpdr_serial_mac import cpdr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mul_ctl                     i_ctl,
    input  logic signed [DATA_WIDTH+3:0] i_a,
    input  logic        [DATA_WIDTH-1:0] i_b,
    output logic                         o_busy,
    output logic signed [DATA_WIDTH-1:0] o_res
);
    // qmul: |a|*|b| rounded >> FRAC_BITS, saturated, signed (a within DATA_WIDTH)
    // div: a / b rounded, ties away from zero (b positive, small)
    // dividend carries four guard bits so a filter sum needs no pre-saturation
    localparam int AW = DATA_WIDTH + 4;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(AW + 1);
    localparam logic [PW-1:0] LMASK = PW'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);

    logic [PW-1:0]         r_acc, n_acc;
    logic [PW-1:0]         r_mcand, n_mcand;
    logic [AW-1:0]         r_mplier, n_mplier;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_busy, n_busy, r_neg, n_neg;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH:0]   r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_b, n_b;
    logic signed [DATA_WIDTH-1:0] r_res, n_res;

    logic [AW-1:0]         abs_a;
    logic [DATA_WIDTH-1:0] abs_b;
    logic [PW-1:0]         rounded, lim;
    logic [DATA_WIDTH:0]   trial, rq;
    logic [DATA_WIDTH:0]   qres;

    always_comb begin
        abs_a = i_a[AW-1] ? AW'(-i_a) : i_a;
        abs_b = i_b[DATA_WIDTH-1] ? DATA_WIDTH'(-i_b) : i_b;
        n_acc = r_acc; n_mcand = r_mcand; n_mplier = r_mplier; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_op = r_op; n_rem = r_rem; n_b = r_b;
        n_res = r_res;
        rounded = (r_acc + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = r_neg ? LMASK + PW'(1) : LMASK;
        trial = {r_rem[DATA_WIDTH-1:0], r_mplier[AW-1]};
        // rounded quotient: quotient + (2*rem >= b)
        rq = {r_rem[DATA_WIDTH-1:0], 1'b0};
        qres = r_acc[DATA_WIDTH:0] + ((rq >= {1'b0, r_b}) ? 1'b1 : 1'b0);
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_cnt  = '0;
            n_acc  = '0;
            n_rem  = '0;
            n_b    = i_b;
            if (i_ctl.op == OP_QMUL) begin
                n_neg    = i_a[AW-1] ^ i_b[DATA_WIDTH-1];
                n_mcand  = PW'(abs_a);
                n_mplier = AW'(abs_b);
            end else begin
                n_neg    = i_a[AW-1];
                n_mplier = abs_a;
            end
        end else if (r_busy) begin
            if (r_cnt == CW'(AW)) begin
                n_busy = 1'b0;
                unique case (r_op)
                    OP_QMUL: begin
                        if (rounded > lim) begin
                            n_res = r_neg ? DATA_WIDTH'(-lim) : DATA_WIDTH'(lim);
                        end else begin
                            n_res = r_neg ? DATA_WIDTH'(-rounded)
                                          : DATA_WIDTH'(rounded);
                        end
                    end
                    default: begin
                        n_res = r_neg ? DATA_WIDTH'(-qres) : DATA_WIDTH'(qres);
                    end
                endcase
            end else begin
                n_cnt = r_cnt + CW'(1);
                unique case (r_op)
                    OP_QMUL: begin
                        if (r_mplier[0]) n_acc = r_acc + r_mcand;
                        n_mcand  = r_mcand << 1;
                        n_mplier = r_mplier >> 1;
                    end
                    default: begin
                        n_mplier = r_mplier << 1;
                        if (trial >= {1'b0, r_b}) begin
                            n_rem = trial - {1'b0, r_b};
                            n_acc = {r_acc[PW-2:0], 1'b1};
                        end else begin
                            n_rem = trial;
                            n_acc = {r_acc[PW-2:0], 1'b0};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc <= n_acc; r_mcand <= n_mcand; r_mplier <= n_mplier; r_cnt <= n_cnt;
        r_neg <= n_neg; r_op <= n_op; r_rem <= n_rem; r_b <= n_b; r_res <= n_res;
    end

    assign o_busy = r_busy | i_ctl.start;
    assign o_res  = r_res;
endmodule
